// ===== design/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types, constants and saturation helper for the Hermite segment unit.
// ----------------------------------------------------------------------------
`default_nettype none
package hse_pkg;

	localparam int FRAC_BITS = 16;
	localparam int Q         = 30;
	localparam int ACC_W     = 96;
	localparam int DIV_STEPS = 64;

	localparam logic signed [33:0] ONE_Q30 = 34'sd1 <<< Q;

	typedef struct packed {
		logic signed [31:0] seg_start;
		logic signed [31:0] seg_end;
		logic signed [31:0] val_start;
		logic signed [31:0] val_end;
		logic signed [31:0] slope_start;
		logic signed [31:0] slope_end;
		logic signed [31:0] query_point;
		logic signed [31:0] query_rate;
	} in_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic signed [31:0] rate_out;
		logic               div_error;
		logic               saturated;
	} rsp_t;

	typedef struct packed {
		logic                  err;
		logic                  neg;
		logic signed [32:0]    h;
		logic signed [32:0]    u;
		logic        [32:0]    den;
		logic        [63:0]    num;
		logic        [63:0]    quo;
		logic        [32:0]    rem;
		logic signed [31:0]    y1;
		logic signed [31:0]    y2;
		logic signed [31:0]    d1;
		logic signed [31:0]    d2;
		logic signed [31:0]    r;
		logic        [30:0]    s;
		logic        [30:0]    s2;
		logic        [30:0]    s3;
		logic signed [33:0]    h00;
		logic signed [33:0]    h01;
		logic signed [33:0]    h10;
		logic signed [33:0]    h11;
		logic signed [33:0]    g;
		logic signed [33:0]    b1;
		logic signed [33:0]    b2;
		logic signed [66:0]    m0;
		logic signed [66:0]    m1;
		logic signed [66:0]    m2;
		logic signed [66:0]    m3;
		logic signed [66:0]    m4;
		logic signed [66:0]    m5;
		logic signed [66:0]    m6;
		logic signed [66:0]    a;
		logic signed [66:0]    b;
		logic signed [66:0]    c;
		logic signed [66:0]    p;
		logic signed [66:0]    pl;
		logic signed [66:0]    ph;
		logic signed [ACC_W-1:0] acc;
		logic signed [31:0]    val;
		logic                  vsat;
	} ctx_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} sat_t;

	function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
		sat_t o;
		if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
			o.val = v[31:0];
			o.sat = 1'b0;
		end else begin
			o.val = v[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			o.sat = 1'b1;
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ===== design/hse_if.sv =====
// ----------------------------------------------------------------------------
// hse_in_if / hse_out_if
// Valid/ready channels for query words and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface hse_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] seg_start;
	logic signed [31:0] seg_end;
	logic signed [31:0] val_start;
	logic signed [31:0] val_end;
	logic signed [31:0] slope_start;
	logic signed [31:0] slope_end;
	logic signed [31:0] query_point;
	logic signed [31:0] query_rate;
	modport source (output valid, seg_start, seg_end, val_start, val_end, slope_start,
		slope_end, query_point, query_rate, input ready);
	modport sink (input valid, seg_start, seg_end, val_start, val_end, slope_start,
		slope_end, query_point, query_rate, output ready);
endinterface

interface hse_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value_out;
	logic signed [31:0] rate_out;
	logic               div_error;
	logic               saturated;
	modport source (output valid, value_out, rate_out, div_error, saturated, input ready);
	modport sink (input valid, value_out, rate_out, div_error, saturated, output ready);
endinterface
`default_nettype wire

// ===== design/hse_front.sv =====
// ----------------------------------------------------------------------------
// hse_front
// Two stages: segment width, query clamp, divider operands.
// ----------------------------------------------------------------------------
`default_nettype none
module hse_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  hse_pkg::in_t      in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output hse_pkg::ctx_t     out_data
);
	logic [1:0]    v_s;
	logic [2:0]    rdy;
	hse_pkg::ctx_t d_s [2];
	hse_pkg::ctx_t nx  [2];

	logic signed [31:0] lo, hi, xc;

	assign rdy[2] = out_ready;
	assign rdy[1] = !v_s[1] || rdy[2];
	assign rdy[0] = !v_s[0] || rdy[1];
	assign in_ready  = rdy[0];
	assign out_valid = v_s[1];
	assign out_data  = d_s[1];

	always_comb begin
		nx[0]    = '0;
		lo       = (in_data.seg_start < in_data.seg_end) ? in_data.seg_start : in_data.seg_end;
		hi       = (in_data.seg_start < in_data.seg_end) ? in_data.seg_end : in_data.seg_start;
		xc       = (in_data.query_point < lo) ? lo :
			((in_data.query_point > hi) ? hi : in_data.query_point);
		nx[0].h  = 33'(in_data.seg_end) - 33'(in_data.seg_start);
		nx[0].u  = 33'(xc) - 33'(in_data.seg_start);
		nx[0].y1 = in_data.val_start;
		nx[0].y2 = in_data.val_end;
		nx[0].d1 = in_data.slope_start;
		nx[0].d2 = in_data.slope_end;
		nx[0].r  = in_data.query_rate;
	end

	always_comb begin
		logic [32:0] um;
		nx[1]     = d_s[0];
		um        = d_s[0].u[32] ? 33'(-d_s[0].u) : 33'(d_s[0].u);
		nx[1].den = d_s[0].h[32] ? 33'(-d_s[0].h) : 33'(d_s[0].h);
		nx[1].num = 64'(um) << hse_pkg::Q;
		nx[1].err = (d_s[0].h == '0);
		nx[1].rem = '0;
		nx[1].quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			if (rdy[1]) v_s[1] <= v_s[0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) d_s[0] <= nx[0];
		if (rdy[1]) d_s[1] <= nx[1];
	end
endmodule
`default_nettype wire

// ===== design/hse_div.sv =====
// ----------------------------------------------------------------------------
// hse_div
// Restoring divider, one quotient bit per register stage, num / den -> quo.
// ----------------------------------------------------------------------------
`default_nettype none
module hse_div (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  hse_pkg::ctx_t     in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output hse_pkg::ctx_t     out_data
);
	localparam int N = hse_pkg::DIV_STEPS;

	logic [N-1:0]  v_s;
	logic [N:0]    rdy;
	hse_pkg::ctx_t d_s [N];

	function automatic hse_pkg::ctx_t step(input hse_pkg::ctx_t c);
		logic [33:0]   rs;
		logic          ge;
		hse_pkg::ctx_t n;
		n     = c;
		rs    = {c.rem, c.num[63]};
		ge    = (rs >= {1'b0, c.den});
		n.rem = ge ? 33'(rs - {1'b0, c.den}) : rs[32:0];
		n.num = {c.num[62:0], 1'b0};
		n.quo = {c.quo[62:0], ge};
		return n;
	endfunction

	assign rdy[N]    = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = v_s[N-1];
	assign out_data  = d_s[N-1];

	for (genvar k = 0; k < N; k++) begin : g_stage
		assign rdy[k] = !v_s[k] || rdy[k+1];
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[k] <= 1'b0;
				else if (rdy[k]) v_s[k] <= in_valid;
			end
			always_ff @(posedge clk) begin
				if (rdy[k]) d_s[k] <= step(in_data);
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[k] <= 1'b0;
				else if (rdy[k]) v_s[k] <= v_s[k-1];
			end
			always_ff @(posedge clk) begin
				if (rdy[k]) d_s[k] <= step(d_s[k-1]);
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/hse_poly.sv =====
// ----------------------------------------------------------------------------
// hse_poly
// Powers of s, Hermite basis, products, value output and second dividend.
// ----------------------------------------------------------------------------
`default_nettype none
module hse_poly (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  hse_pkg::ctx_t     in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output hse_pkg::ctx_t     out_data
);
	localparam int N = 8;

	logic [N-1:0]  v_s;
	logic [N:0]    rdy;
	hse_pkg::ctx_t d_s [N];
	hse_pkg::ctx_t nx  [N];

	assign rdy[N]    = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = v_s[N-1];
	assign out_data  = d_s[N-1];

	// s and s^2
	always_comb begin
		logic [61:0] pr;
		nx[0]    = in_data;
		nx[0].s  = in_data.quo[30:0];
		pr       = 62'(in_data.quo[30:0]) * 62'(in_data.quo[30:0]);
		nx[0].s2 = pr[60:30];
	end

	// s^3
	always_comb begin
		logic [61:0] pr;
		nx[1]    = d_s[0];
		pr       = 62'(d_s[0].s2) * 62'(d_s[0].s);
		nx[1].s3 = pr[60:30];
	end

	// basis
	always_comb begin
		logic signed [33:0] e1, e2, e3;
		nx[2]     = d_s[1];
		e1        = $signed({3'b000, d_s[1].s});
		e2        = $signed({3'b000, d_s[1].s2});
		e3        = $signed({3'b000, d_s[1].s3});
		nx[2].h00 = e3 + e3 - e2 - e2 - e2 + hse_pkg::ONE_Q30;
		nx[2].h01 = e2 + e2 + e2 - e3 - e3;
		nx[2].h10 = e3 - e2 - e2 + e1;
		nx[2].h11 = e3 - e2;
		nx[2].g   = (e2 - e1) * 34'sd6;
		nx[2].b1  = e2 + e2 + e2 - (e1 <<< 2) + hse_pkg::ONE_Q30;
		nx[2].b2  = e2 + e2 + e2 - e1 - e1;
	end

	// products
	always_comb begin
		logic signed [32:0] yd;
		nx[3]    = d_s[2];
		yd       = 33'(d_s[2].y1) - 33'(d_s[2].y2);
		nx[3].m0 = d_s[2].h00 * d_s[2].y1;
		nx[3].m1 = d_s[2].h01 * d_s[2].y2;
		nx[3].m2 = d_s[2].h10 * d_s[2].d1;
		nx[3].m3 = d_s[2].h11 * d_s[2].d2;
		nx[3].m4 = d_s[2].g * yd;
		nx[3].m5 = d_s[2].b1 * d_s[2].d1;
		nx[3].m6 = d_s[2].b2 * d_s[2].d2;
	end

	// sums and dividend of the slope term
	always_comb begin
		logic signed [66:0] am;
		nx[4]     = d_s[3];
		nx[4].a   = d_s[3].m0 + d_s[3].m1;
		nx[4].b   = d_s[3].m2 + d_s[3].m3;
		nx[4].c   = d_s[3].m5 + d_s[3].m6;
		am        = d_s[3].m4[66] ? -d_s[3].m4 : d_s[3].m4;
		nx[4].num = am[63:0];
		nx[4].neg = d_s[3].m4[66] ^ d_s[3].h[32];
		nx[4].rem = '0;
		nx[4].quo = '0;
	end

	// h * b in two partial products
	always_comb begin
		nx[5]    = d_s[4];
		nx[5].pl = d_s[4].h * $signed({1'b0, d_s[4].b[31:0]});
		nx[5].ph = d_s[4].h * $signed(d_s[4].b[66:32]);
	end

	always_comb begin
		nx[6]     = d_s[5];
		nx[6].acc = (hse_pkg::ACC_W'(d_s[5].a) <<< hse_pkg::FRAC_BITS)
			+ (hse_pkg::ACC_W'(d_s[5].ph) <<< 32) + hse_pkg::ACC_W'(d_s[5].pl);
	end

	always_comb begin
		hse_pkg::sat_t sv;
		nx[7]      = d_s[6];
		sv         = hse_pkg::sat32(d_s[6].acc >>> (hse_pkg::Q + hse_pkg::FRAC_BITS));
		nx[7].val  = sv.val;
		nx[7].vsat = sv.sat;
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		assign rdy[k] = !v_s[k] || rdy[k+1];
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[k] <= 1'b0;
				else if (rdy[k]) v_s[k] <= in_valid;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[k] <= 1'b0;
				else if (rdy[k]) v_s[k] <= v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (rdy[k]) d_s[k] <= nx[k];
		end
	end
endmodule
`default_nettype wire

// ===== design/hse_back.sv =====
// ----------------------------------------------------------------------------
// hse_back
// Slope sum, rate scaling in partial products, saturation, result word.
// ----------------------------------------------------------------------------
`default_nettype none
module hse_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  hse_pkg::ctx_t     in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output hse_pkg::rsp_t     out_data
);
	logic [3:0]    v_s;
	logic [4:0]    rdy;
	hse_pkg::ctx_t d_s [3];
	hse_pkg::ctx_t nx  [3];
	hse_pkg::rsp_t o_s3;
	hse_pkg::rsp_t o_nx;

	assign rdy[4]    = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = v_s[3];
	assign out_data  = o_s3;

	always_comb begin
		logic signed [64:0] t;
		nx[0]   = in_data;
		t       = $signed({1'b0, in_data.quo});
		if (in_data.neg) t = -t;
		nx[0].p = 67'(t) + (in_data.c >>> hse_pkg::FRAC_BITS);
	end

	always_comb begin
		nx[1]    = d_s[0];
		nx[1].pl = d_s[0].r * $signed({1'b0, d_s[0].p[31:0]});
		nx[1].ph = d_s[0].r * $signed(d_s[0].p[66:32]);
	end

	always_comb begin
		nx[2]     = d_s[1];
		nx[2].acc = (hse_pkg::ACC_W'(d_s[1].ph) <<< 32) + hse_pkg::ACC_W'(d_s[1].pl);
	end

	always_comb begin
		hse_pkg::sat_t sr;
		sr = hse_pkg::sat32(d_s[2].acc >>> hse_pkg::Q);
		if (d_s[2].err) begin
			o_nx = '{value_out: '0, rate_out: '0, div_error: 1'b1, saturated: 1'b0};
		end else begin
			o_nx.value_out = d_s[2].val;
			o_nx.rate_out  = sr.val;
			o_nx.div_error = 1'b0;
			o_nx.saturated = d_s[2].vsat | sr.sat;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_rdy
		assign rdy[k] = !v_s[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			if (rdy[1]) v_s[1] <= v_s[0];
			if (rdy[2]) v_s[2] <= v_s[1];
			if (rdy[3]) v_s[3] <= v_s[2];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) d_s[0] <= nx[0];
		if (rdy[1]) d_s[1] <= nx[1];
		if (rdy[2]) d_s[2] <= nx[2];
		if (rdy[3]) o_s3   <= o_nx;
	end
endmodule
`default_nettype wire

// ===== design/cubic_hermite_segment_eval_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_hermite_segment_eval_unit
// Cubic Hermite segment evaluator: value and time derivative, Q16.16.
// ----------------------------------------------------------------------------
// Takes one query word per clock when the output is not stalled and returns
// one result word per query, in order. The pipeline is made of 2 front
// stages, two 64-stage restoring dividers (one quotient bit per stage, for the
// curve parameter and for the slope term), 8 polynomial stages and 4 output
// stages. Every stage has its own valid bit, so back-pressure only halts
// stages that hold data and bubbles close up.
`default_nettype none
module cubic_hermite_segment_eval_unit (
	input  wire        clk,
	input  wire        arst_n,
	hse_in_if.sink     req,
	hse_out_if.source  rsp
);
	hse_pkg::in_t  in_w;
	hse_pkg::ctx_t f_d, d1_d, p_d, d2_d;
	hse_pkg::rsp_t o_d;
	logic f_v, f_r, d1_v, d1_r, p_v, p_r, d2_v, d2_r;

	always_comb begin
		in_w.seg_start   = req.seg_start;
		in_w.seg_end     = req.seg_end;
		in_w.val_start   = req.val_start;
		in_w.val_end     = req.val_end;
		in_w.slope_start = req.slope_start;
		in_w.slope_end   = req.slope_end;
		in_w.query_point = req.query_point;
		in_w.query_rate  = req.query_rate;
	end

	hse_front u_front (.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.in_data(in_w), .out_valid(f_v), .out_ready(f_r), .out_data(f_d));

	hse_div u_div_s (.clk(clk), .arst_n(arst_n), .in_valid(f_v), .in_ready(f_r),
		.in_data(f_d), .out_valid(d1_v), .out_ready(d1_r), .out_data(d1_d));

	hse_poly u_poly (.clk(clk), .arst_n(arst_n), .in_valid(d1_v), .in_ready(d1_r),
		.in_data(d1_d), .out_valid(p_v), .out_ready(p_r), .out_data(p_d));

	hse_div u_div_p (.clk(clk), .arst_n(arst_n), .in_valid(p_v), .in_ready(p_r),
		.in_data(p_d), .out_valid(d2_v), .out_ready(d2_r), .out_data(d2_d));

	hse_back u_back (.clk(clk), .arst_n(arst_n), .in_valid(d2_v), .in_ready(d2_r),
		.in_data(d2_d), .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(o_d));

	assign rsp.value_out = o_d.value_out;
	assign rsp.rate_out  = o_d.rate_out;
	assign rsp.div_error = o_d.div_error;
	assign rsp.saturated = o_d.saturated;
endmodule
`default_nettype wire

// ===== design/hse_checker.sv =====
// ----------------------------------------------------------------------------
// hse_checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module hse_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        rsp_valid,
	input wire        rsp_ready,
	input wire [31:0] value_out,
	input wire [31:0] rate_out,
	input wire        div_error,
	input wire        saturated
);
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && div_error |-> value_out == '0 && rate_out == '0 && !saturated)
		else $error("error word with non-zero payload");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && saturated |-> value_out == 32'h7FFF_FFFF || value_out == 32'h8000_0000
			|| rate_out == 32'h7FFF_FFFF || rate_out == 32'h8000_0000)
		else $error("saturated flag without a clipped output");

	a_rst_idle: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(value_out) && $stable(rate_out)
			&& $stable(div_error) && $stable(saturated))
		else $error("stalled result word changed");
endmodule

bind cubic_hermite_segment_eval_unit hse_checker u_hse_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.value_out(rsp.value_out), .rate_out(rsp.rate_out), .div_error(rsp.div_error),
	.saturated(rsp.saturated));
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cubic_hermite_segment_eval_unit. A directed table
// covers equal ends, reversed ends, clamped queries and saturating extremes.
// Random words follow. Both channels idle at random, the result side holds
// off for a long stretch once, and the query side drains once mid-run. Every result
// is checked in order against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;

	localparam int N_RANDOM  = 830;
	localparam int LIMIT     = 400000;
	localparam int TAIL      = 300;
	localparam int HOLD_CYC  = 600;

	localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;

	typedef struct {
		hse_pkg::in_t  w;
		bit            typed;
		hse_pkg::rsp_t exp;
	} row_t;

	logic clk;
	logic arst_n;
	int   cyc;
	int   errors;
	bit   hold_req;
	bit   drained;

	hse_in_if  req ();
	hse_out_if rsp ();

	cubic_hermite_segment_eval_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	hse_pkg::rsp_t expected_q[$];
	hse_pkg::rsp_t typed_q[$];
	bit            typed_flag_q[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic signed [31:0] clip32(input logic signed [127:0] v, inout bit sat);
		if (v > 128'sh7FFF_FFFF) begin
			sat = 1'b1;
			return MAXV;
		end
		if (v < -128'sh8000_0000) begin
			sat = 1'b1;
			return MINV;
		end
		return v[31:0];
	endfunction

	function automatic hse_pkg::rsp_t hermite_eval(input hse_pkg::in_t w);
		logic signed [127:0] x1, x2, y1, y2, d1, d2, x, r, h, lo, hi, xc, u;
		logic signed [127:0] s, s2, s3, h00, h01, h10, h11, a, b, acc, g, b1, b2, p;
		logic [127:0] num, den;
		bit sat;
		hse_pkg::rsp_t o;
		x1 = w.seg_start;  x2 = w.seg_end;
		y1 = w.val_start;  y2 = w.val_end;
		d1 = w.slope_start; d2 = w.slope_end;
		x  = w.query_point; r = w.query_rate;
		h  = x2 - x1;
		o = '0;
		if (h == 0) begin
			o.div_error = 1'b1;
			return o;
		end
		lo = (x1 < x2) ? x1 : x2;
		hi = (x1 < x2) ? x2 : x1;
		xc = (x < lo) ? lo : ((x > hi) ? hi : x);
		u  = xc - x1;
		num = (u < 0) ? -u : u;
		num = num << 30;
		den = (h < 0) ? -h : h;
		s  = $signed(num / den);
		s2 = (s * s) >>> 30;
		s3 = (s2 * s) >>> 30;
		h00 = 2 * s3 - 3 * s2 + (128'sd1 <<< 30);
		h01 = 3 * s2 - 2 * s3;
		h10 = s3 - 2 * s2 + s;
		h11 = s3 - s2;
		a = h00 * y1 + h01 * y2;
		b = h10 * d1 + h11 * d2;
		acc = (a <<< hse_pkg::FRAC_BITS) + h * b;
		sat = 1'b0;
		o.value_out = clip32(acc >>> (30 + hse_pkg::FRAC_BITS), sat);
		g  = 6 * s2 - 6 * s;
		b1 = 3 * s2 - 4 * s + (128'sd1 <<< 30);
		b2 = 3 * s2 - 2 * s;
		p  = (g * (y1 - y2)) / h + ((b1 * d1 + b2 * d2) >>> hse_pkg::FRAC_BITS);
		o.rate_out  = clip32((r * p) >>> 30, sat);
		o.saturated = sat;
		return o;
	endfunction

	function automatic logic signed [31:0] rnd_small(input int bits);
		logic signed [31:0] v;
		v = $urandom;
		return v >>> (32 - bits);
	endfunction

	function automatic hse_pkg::in_t random_word();
		hse_pkg::in_t w;
		int  mode;
		mode = $urandom_range(0, 19);
		if (mode < 6) begin
			w = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
		end else begin
			w.seg_start   = rnd_small($urandom_range(8, 26));
			w.seg_end     = w.seg_start + rnd_small($urandom_range(4, 24));
			w.val_start   = rnd_small($urandom_range(8, 28));
			w.val_end     = rnd_small($urandom_range(8, 28));
			w.slope_start = rnd_small($urandom_range(8, 26));
			w.slope_end   = rnd_small($urandom_range(8, 26));
			w.query_rate  = rnd_small($urandom_range(8, 22));
			if (mode < 16)
				w.query_point = w.seg_start
					+ ((w.seg_end - w.seg_start) >>> $urandom_range(0, 3));
			else
				w.query_point = rnd_small($urandom_range(8, 30));
			if (mode == 19)
				w.seg_end = w.seg_start;
		end
		return w;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		errors++;
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cyc);
	endtask

	function automatic hse_pkg::in_t mk(input logic signed [31:0] x1, x2, y1, y2, d1, d2, x, r);
		hse_pkg::in_t w;
		w = {x1, x2, y1, y2, d1, d2, x, r};
		return w;
	endfunction

	row_t table_q[$];

	task automatic build_table();
		hse_pkg::rsp_t de;
		de = '0;
		de.div_error = 1'b1;
		table_q.push_back('{mk(ONE, ONE, MAXV, MINV, MAXV, MINV, MAXV, MAXV), 1, de});
		table_q.push_back('{mk(MINV, MINV, 5, 7, 9, 11, 0, ONE), 1, de});
		table_q.push_back('{mk(MAXV, MAXV, 0, 0, 0, 0, MINV, MINV), 1, de});
		table_q.push_back('{mk(0, ONE, 0, ONE, 0, 0, ONE / 2, ONE), 0, '0});
		table_q.push_back('{mk(0, ONE, 0, ONE, ONE, ONE, ONE / 4, ONE), 0, '0});
		table_q.push_back('{mk(ONE, 0, 0, ONE, ONE, -ONE, ONE / 3, ONE), 0, '0});
		table_q.push_back('{mk(0, 4 * ONE, ONE, 3 * ONE, ONE, ONE, -ONE, 2 * ONE), 0, '0});
		table_q.push_back('{mk(0, 4 * ONE, ONE, 3 * ONE, ONE, ONE, 9 * ONE, 2 * ONE), 0, '0});
		table_q.push_back('{mk(4 * ONE, 0, ONE, 3 * ONE, ONE, -ONE, 9 * ONE, -ONE), 0, '0});
		table_q.push_back('{mk(4 * ONE, 0, ONE, 3 * ONE, ONE, -ONE, MINV, ONE), 0, '0});
		table_q.push_back('{mk(MINV, MAXV, MAXV, MAXV, MAXV, MAXV, 0, MAXV), 0, '0});
		table_q.push_back('{mk(MINV, MAXV, MINV, MINV, MINV, MINV, 0, MAXV), 0, '0});
		table_q.push_back('{mk(MAXV, MINV, MAXV, MINV, MINV, MAXV, 12345, MINV), 0, '0});
		table_q.push_back('{mk(0, 1, MAXV, MINV, MAXV, MAXV, 0, MAXV), 0, '0});
		table_q.push_back('{mk(0, 1, MINV, MAXV, MINV, MINV, 1, MINV), 0, '0});
		table_q.push_back('{mk(-1, 0, 0, 0, 0, 0, MAXV, MAXV), 0, '0});
		table_q.push_back('{mk(MINV, MINV + 1, MAXV, MINV, MAXV, MINV, MINV, MAXV), 0, '0});
		table_q.push_back('{mk(0, ONE, ONE, -ONE, MAXV, MINV, ONE / 2, 0), 0, '0});
		table_q.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, de});
		table_q.push_back('{mk(-ONE, ONE, -1, 1, -1, 1, -1, -1), 0, '0});
	endtask

	task automatic send(input hse_pkg::in_t w);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid       <= 1'b1;
		req.seg_start   <= w.seg_start;
		req.seg_end     <= w.seg_end;
		req.val_start   <= w.val_start;
		req.val_end     <= w.val_end;
		req.slope_start <= w.slope_start;
		req.slope_end   <= w.slope_end;
		req.query_point <= w.query_point;
		req.query_rate  <= w.query_rate;
		do @(posedge clk); while (!req.ready);
	endtask

	// query side
	initial begin
		req.valid <= 1'b0;
		{req.seg_start, req.seg_end, req.val_start, req.val_end,
			req.slope_start, req.slope_end, req.query_point, req.query_rate} <= '0;
		hold_req = 1'b0;
		drained  = 1'b0;
		build_table();
		@(posedge arst_n);
		@(posedge clk);
		foreach (table_q[i]) begin
			typed_flag_q.push_back(table_q[i].typed);
			typed_q.push_back(table_q[i].exp);
			send(table_q[i].w);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			typed_flag_q.push_back(1'b0);
			typed_q.push_back('0);
			if (i == 200)
				hold_req = 1'b1;
			if (i == 500) begin
				req.valid <= 1'b0;
				@(posedge clk);
				while (expected_q.size() != 0) @(posedge clk);
			end
			send(random_word());
		end
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		drained = 1'b1;
	end

	// result side
	initial begin
		int gap;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				rsp.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYC; c++) @(posedge clk);
			end else begin
				gap = $urandom_range(0, 8);
				if ($urandom_range(0, 3) == 0)
					gap = 0;
				if (gap > 0) begin
					rsp.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// monitor
	always @(posedge clk) begin
		hse_pkg::rsp_t got, exp;
		hse_pkg::in_t  w;
		cyc <= cyc + 1;
		if (arst_n && req.valid && req.ready) begin
			w = {req.seg_start, req.seg_end, req.val_start, req.val_end,
				req.slope_start, req.slope_end, req.query_point, req.query_rate};
			exp = hermite_eval(w);
			if (typed_flag_q.size() != 0 && typed_flag_q.pop_front())
				exp = typed_q.pop_front();
			else if (typed_q.size() != 0)
				void'(typed_q.pop_front());
			expected_q.push_back(exp);
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.value_out, rsp.rate_out, rsp.div_error, rsp.saturated};
			if (expected_q.size() == 0) begin
				report("unexpected word", got.value_out, 32'h0);
			end else begin
				exp = expected_q.pop_front();
				if (got.value_out !== exp.value_out)
					report("value_out", got.value_out, exp.value_out);
				if (got.rate_out !== exp.rate_out)
					report("rate_out", got.rate_out, exp.rate_out);
				if (got.div_error !== exp.div_error)
					report("div_error", 32'(got.div_error), 32'(exp.div_error));
				if (got.saturated !== exp.saturated)
					report("saturated", 32'(got.saturated), 32'(exp.saturated));
			end
		end
	end

	initial begin
		cyc    = 0;
		errors = 0;
		fork
			wait (drained);
			wait (cyc > LIMIT);
		join_any
		if (!drained) begin
			$display("tb: failure");
			$finish;
		end else begin
			if (errors == 0 && expected_q.size() == 0)
				$display("tb: success");
			else
				$display("tb: failure");
			$finish;
		end
	end

endmodule
